// ===== hdl/lpr_pkg.sv =====
// Shared types and constants for the line pixel rasterizer.
// Register indexes, register widths and reset values, and queue status.
// No dependencies.
package lpr_pkg;

   localparam int COLOR_BITS     = 8;
   localparam int LIMIT_BITS     = 7;
   localparam int CFG_INDEX_BITS = 2;
   localparam int CFG_DATA_BITS  = 8;

   localparam logic [COLOR_BITS-1:0] FILL_COLOR_RESET    = 8'd255;
   localparam logic [COLOR_BITS-1:0] COLOR_CEILING_RESET = 8'd255;
   localparam logic [LIMIT_BITS-1:0] X_LIMIT_RESET       = 7'd32;
   localparam logic [LIMIT_BITS-1:0] Y_LIMIT_RESET       = 7'd30;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef enum logic [CFG_INDEX_BITS-1:0] {
      CFG_FILL_COLOR    = 2'd0,
      CFG_COLOR_CEILING = 2'd1,
      CFG_X_LIMIT       = 2'd2,
      CFG_Y_LIMIT       = 2'd3
   } cfg_reg_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] fill_color;
      logic [COLOR_BITS-1:0] color_ceiling;
      logic [LIMIT_BITS-1:0] x_limit;
      logic [LIMIT_BITS-1:0] y_limit;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hdl/lpr_front.sv =====
// Front end: takes line requests and works out span, direction and the
// initial error term. Depends on lpr_pkg.
module lpr_front
   import lpr_pkg::*;
#(
   parameter int COORD_BITS = 6,
   parameter int REQ_DATA_BITS = 24,
   parameter int ERR_BITS = 9,
   parameter int DESC_BITS = 6*6 + 2 + 9
) (
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  queue_status_type         q_status,
   output logic                     push,
   output logic [DESC_BITS-1:0]     desc
);

   logic [COORD_BITS-1:0]      x0, y0, xe, ye, dx, dy;
   logic                       sx, sy;
   logic signed [ERR_BITS-1:0] err0;

   assign x0 = req_tdata[COORD_BITS-1:0];
   assign y0 = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign xe = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign ye = req_tdata[4*COORD_BITS-1:3*COORD_BITS];

   always_comb begin
      dx = (x0 > xe) ? x0 - xe : xe - x0;
      dy = (y0 > ye) ? y0 - ye : ye - y0;
      sx = (x0 < xe);
      sy = (y0 < ye);
      // start at half the major span, negative when y is the major axis or dx == dy
      if (dx > dy) begin
         err0 = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, dx >> 1});
      end else begin
         err0 = -$signed({{(ERR_BITS-COORD_BITS){1'b0}}, dy >> 1});
      end
   end

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && !q_status.full;
   assign desc       = {err0, sy, sx, dy, dx, ye, xe, y0, x0};

endmodule

// ===== hdl/lpr_queue.sv =====
// Short queue of line descriptors between front and back end.
// Depends on lpr_pkg.
module lpr_queue
   import lpr_pkg::*;
#(
   parameter int WIDTH = 47
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type q_status
);

   logic [WIDTH-1:0]   entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] ptr);
      return (ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign q_status.full  = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_data       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
      end
      if (pop) begin
         rd_ptr_in = next_ptr(rd_ptr_ff);
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/lpr_back.sv =====
// Back end: walks one line with the Bresenham error term into the result
// register, one pixel per cycle unless stalled. Depends on lpr_pkg.
module lpr_back
   import lpr_pkg::*;
#(
   parameter int COORD_BITS = 6,
   parameter int RSP_DATA_BITS = 24,
   parameter int ERR_BITS = 9,
   parameter int DESC_BITS = 6*6 + 2 + 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  queue_status_type         q_status,
   input  logic [DESC_BITS-1:0]     desc,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);

   localparam int C = COORD_BITS;

   logic                       active_ff, active_in;
   logic [C-1:0]               x_ff, x_in, y_ff, y_in, xe_ff, xe_in, ye_ff, ye_in;
   logic [C-1:0]               dx_ff, dx_in, dy_ff, dy_in;
   logic                       sx_ff, sx_in, sy_ff, sy_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [C-1:0]               px_ff, px_in, py_ff, py_in;
   logic [COLOR_BITS-1:0]      color_ff, color_in;
   logic                       vis_ff, vis_in, last_ff, last_in;

   logic                       out_free, emit, done;
   logic signed [ERR_BITS-1:0] dx_s, dy_s;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign pop      = !active_ff && !q_status.empty;
   assign emit     = active_ff && out_free;
   assign done     = (x_ff == xe_ff) && (y_ff == ye_ff);
   assign dx_s     = $signed({{(ERR_BITS-C){1'b0}}, dx_ff});
   assign dy_s     = $signed({{(ERR_BITS-C){1'b0}}, dy_ff});

   always_comb begin
      active_in    = active_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      xe_in        = xe_ff;
      ye_in        = ye_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      px_in        = px_ff;
      py_in        = py_ff;
      color_in     = color_ff;
      vis_in       = vis_ff;
      last_in      = last_ff;

      if (pop) begin
         // load the next line from the queue
         active_in = 1'b1;
         x_in      = desc[C-1:0];
         y_in      = desc[2*C-1:C];
         xe_in     = desc[3*C-1:2*C];
         ye_in     = desc[4*C-1:3*C];
         dx_in     = desc[5*C-1:4*C];
         dy_in     = desc[6*C-1:5*C];
         sx_in     = desc[6*C];
         sy_in     = desc[6*C+1];
         err_in    = $signed(desc[6*C+2+ERR_BITS-1:6*C+2]);
      end else if (emit) begin
         rsp_valid_in = 1'b1;
         px_in        = x_ff;
         py_in        = y_ff;
         color_in     = (cfg.fill_color >= cfg.color_ceiling) ? cfg.color_ceiling
                                                               : cfg.fill_color;
         vis_in       = ({{(LIMIT_BITS-C){1'b0}}, x_ff} < cfg.x_limit) &&
                        ({{(LIMIT_BITS-C){1'b0}}, y_ff} < cfg.y_limit);
         last_in      = done;
         if (done) begin
            active_in = 1'b0;
         end else begin
            // both tests use the error value from before this step
            if (err_ff > -dx_s && err_ff < dy_s) begin
               err_in = err_ff - dy_s + dx_s;
            end else if (err_ff > -dx_s) begin
               err_in = err_ff - dy_s;
            end else if (err_ff < dy_s) begin
               err_in = err_ff + dx_s;
            end
            if (err_ff > -dx_s) begin
               x_in = sx_ff ? x_ff + 1'b1 : x_ff - 1'b1;
            end
            if (err_ff < dy_s) begin
               y_in = sy_ff ? y_ff + 1'b1 : y_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      xe_ff    <= xe_in;
      ye_ff    <= ye_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      err_ff   <= err_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      color_ff <= color_in;
      vis_ff   <= vis_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({color_ff, py_ff, px_ff});
   assign rsp_tuser  = vis_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== hdl/line_pixel_rasterizer.sv =====
// Bresenham line rasterizer, top level: configuration registers, front end,
// descriptor queue and pixel walker. Depends on lpr_pkg, lpr_front,
// lpr_queue and lpr_back.
//
// Usage: each request on req_* carries one line, start and end point.
// The block answers on rsp_* with one pixel per result, start to end
// inclusive, tlast on the end point. A line of spans dx, dy gives
// max(dx, dy) + 1 results, at most 2^COORD_BITS.
// A request passes through the descriptor queue and the walker's line
// registers, and each pixel is registered before rsp_tvalid rises. The
// walker gives one pixel per cycle unless rsp_tready stalls it, and loads
// the next descriptor only once the current line is done.
// Requests are taken while the two-entry queue has room, so up to two
// further lines wait while one is drawn.
// A stalled rsp_tready holds the current pixel and stops the walk; the
// queue then fills and req_tready drops.
// Reset (synchronous) empties the queue, drops any line in progress and loads the
// register defaults: fill color 255, ceiling 255, x limit 32, y limit 30. The
// user must write registers via csr_* only while the block is idle; unenforced.
module line_pixel_rasterizer
   import lpr_pkg::*;
#(
   parameter int COORD_BITS = 6,
   localparam int REQ_DATA_BITS = ((4*COORD_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((2*COORD_BITS + COLOR_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CFG_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,  // x_start, y_start, x_end, y_end
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,  // pixel_x, pixel_y, pixel_color
   output logic                      rsp_tuser,  // visible
   output logic                      rsp_tlast
);

   localparam int ERR_BITS  = COORD_BITS + 3;
   localparam int DESC_BITS = 6*COORD_BITS + 2 + ERR_BITS;

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   logic             push, pop;
   logic [DESC_BITS-1:0] push_desc, pop_desc;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (cfg_reg_type'(csr_index))
            CFG_FILL_COLOR:    cfg_in.fill_color    = csr_wdata[COLOR_BITS-1:0];
            CFG_COLOR_CEILING: cfg_in.color_ceiling = csr_wdata[COLOR_BITS-1:0];
            CFG_X_LIMIT:       cfg_in.x_limit       = csr_wdata[LIMIT_BITS-1:0];
            CFG_Y_LIMIT:       cfg_in.y_limit       = csr_wdata[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fill_color    <= FILL_COLOR_RESET;
         cfg_ff.color_ceiling <= COLOR_CEILING_RESET;
         cfg_ff.x_limit       <= X_LIMIT_RESET;
         cfg_ff.y_limit       <= Y_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpr_front #(
      .COORD_BITS(COORD_BITS),
      .REQ_DATA_BITS(REQ_DATA_BITS),
      .ERR_BITS(ERR_BITS),
      .DESC_BITS(DESC_BITS)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .q_status  (q_status),
      .push      (push),
      .desc      (push_desc)
   );

   lpr_queue #(
      .WIDTH(DESC_BITS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_desc),
      .pop      (pop),
      .pop_data (pop_desc),
      .q_status (q_status)
   );

   lpr_back #(
      .COORD_BITS(COORD_BITS),
      .RSP_DATA_BITS(RSP_DATA_BITS),
      .ERR_BITS(ERR_BITS),
      .DESC_BITS(DESC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .desc      (pop_desc),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("descriptor taken from an empty queue");

   a_visible_x: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (LIMIT_BITS'(rsp_tdata[COORD_BITS-1:0]) < cfg_ff.x_limit))
      else $error("visible pixel lies outside the x limit");

   a_color_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS] <= cfg_ff.color_ceiling))
      else $error("pixel color above the color ceiling");
`endif

endmodule
